FILE: rtl/core/sbeq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbeq_pkg: shared types, constants and coefficient maths
// Control word of the equaliser sequencer, datapath widths, band tables and
// the elaboration-time function that builds the one-pole coefficients.
// ----------------------------------------------------------------------------
package sbeq_pkg;

  localparam int unsigned DEF_SAMPLE_RATE  = 48000;
  localparam int unsigned DEF_SAMPLE_WIDTH = 24;
  localparam int unsigned MIN_RATE         = 44100;

  localparam int unsigned NUM_BANDS = 6;
  localparam int unsigned BAND_W    = 3;
  localparam int unsigned STEP_W    = 3;
  localparam int unsigned LEVEL_W   = 17;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned STATE_W = 32;
  localparam int unsigned HALF_W  = 30;
  localparam int unsigned HP_W    = 33;
  localparam int unsigned DIFF_W  = 35;
  localparam int unsigned COEF_W  = 24;
  localparam int unsigned MUL_B_W = 25;
  localparam int unsigned PROD_W  = 60;
  localparam int unsigned GAIN_W  = 23;
  localparam int unsigned ACC_W   = 58;
  localparam int unsigned FRAC_SH = 24;

  localparam int unsigned HP_FREQ [NUM_BANDS] = '{30, 300, 120, 1000, 900, 3000};
  localparam int unsigned LP_FREQ [NUM_BANDS] = '{120, 500, 900, 2000, 20000, 20000};
  localparam logic [2:0] LEVEL_MAP [NUM_BANDS] = '{3'd0, 3'd3, 3'd1, 3'd4, 3'd2, 3'd5};
  localparam logic [4:0] GAIN_MUL  [NUM_BANDS] = '{5'd8, 5'd4, 5'd4, 5'd4, 5'd8, 5'd24};
  localparam logic [3:0] GAIN_OFF  [NUM_BANDS] = '{4'd0, 4'd0, 4'd2, 4'd0, 4'd2, 4'd12};
  localparam logic [LEVEL_W-1:0] LEVEL_RESET [NUM_BANDS] =
    '{17'd32768, 17'd32768, 17'd32768, 17'd0, 17'd0, 17'd0};

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_HP,
    MUL_LP,
    MUL_GAIN
  } mul_sel_e;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_HP,
    UPD_LP
  } upd_sel_e;

  typedef struct packed {
    mul_sel_e          mul_sel;
    upd_sel_e          upd_sel;
    logic              acc_add;
    logic              band_inc;
    logic              jmp;
    logic [STEP_W-1:0] target;
    logic              fin;
  } ctrl_t;

  localparam logic [63:0] Q56_ONE  = 64'h0100_0000_0000_0000;
  localparam logic [63:0] TWO_PI56 = 64'h0648_7ED5_110B_4612;

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] mul_q56(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ah, al, bh, bl, mid;
    ah  = a >> 28;
    al  = a & 64'h0FFF_FFFF;
    bh  = b >> 28;
    bl  = b & 64'h0FFF_FFFF;
    mid = ah * bl + al * bh + ((al * bl) >> 28);
    return ah * bh + (mid >> 28);
  endfunction

  // Q0.24 value of 1 - exp(-2*pi*f/rate), alternating series in Q56
  function automatic logic [COEF_W-1:0] make_coef(input int unsigned f,
                                                  input int unsigned rate);
    logic [63:0] q, r, x, t;
    logic signed [63:0] s, c;
    q = udiv64(TWO_PI56, 64'(rate));
    r = TWO_PI56 - q * 64'(rate);
    x = q * 64'(f) + udiv64(r * 64'(f), 64'(rate));
    t = Q56_ONE;
    s = $signed(Q56_ONE);
    for (int n = 1; n <= 64; n++) begin
      t = udiv64(mul_q56(t, x), 64'(n));
      if (n % 2 == 1) begin
        s = s - $signed(t);
      end else begin
        s = s + $signed(t);
      end
    end
    c = $signed(Q56_ONE) - s;
    if (c < 0) begin
      c = '0;
    end
    c = c + 64'sh8000_0000;
    return c[55:32];
  endfunction

endpackage

FILE: rtl/core/sbeq_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbeq_seq: microprogram sequencer
// Step counter, band counter and program table. Each step issues one control
// word to the datapath; the last band step jumps back until all bands are done.
// ----------------------------------------------------------------------------
module sbeq_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        clear_i,
  input  logic                        stall_i,
  output logic                        busy_o,
  output logic [sbeq_pkg::BAND_W-1:0] band_o,
  output sbeq_pkg::ctrl_t             ctrl_o
);

  localparam logic [sbeq_pkg::STEP_W-1:0] STEP_HP_MUL = 3'd0;
  localparam logic [sbeq_pkg::STEP_W-1:0] STEP_HP_UPD = 3'd1;
  localparam logic [sbeq_pkg::STEP_W-1:0] STEP_LP_MUL = 3'd2;
  localparam logic [sbeq_pkg::STEP_W-1:0] STEP_LP_UPD = 3'd3;
  localparam logic [sbeq_pkg::STEP_W-1:0] STEP_GN_MUL = 3'd4;
  localparam logic [sbeq_pkg::STEP_W-1:0] STEP_ACC    = 3'd5;
  localparam logic [sbeq_pkg::STEP_W-1:0] STEP_OUT    = 3'd6;
  localparam logic [sbeq_pkg::BAND_W-1:0] LAST_BAND   =
    sbeq_pkg::BAND_W'(sbeq_pkg::NUM_BANDS - 1);

  function automatic sbeq_pkg::ctrl_t rom(input logic [sbeq_pkg::STEP_W-1:0] pc);
    sbeq_pkg::ctrl_t w;
    w = '{mul_sel: sbeq_pkg::MUL_NONE, upd_sel: sbeq_pkg::UPD_NONE, acc_add: 1'b0,
          band_inc: 1'b0, jmp: 1'b0, target: STEP_HP_MUL, fin: 1'b0};
    case (pc)
      STEP_HP_MUL: begin
        w.mul_sel = sbeq_pkg::MUL_HP;
        w.acc_add = 1'b1;
      end
      STEP_HP_UPD: w.upd_sel = sbeq_pkg::UPD_HP;
      STEP_LP_MUL: w.mul_sel = sbeq_pkg::MUL_LP;
      STEP_LP_UPD: w.upd_sel = sbeq_pkg::UPD_LP;
      STEP_GN_MUL: begin
        w.mul_sel  = sbeq_pkg::MUL_GAIN;
        w.band_inc = 1'b1;
        w.jmp      = 1'b1;
        w.target   = STEP_HP_MUL;
      end
      STEP_ACC:    w.acc_add = 1'b1;
      STEP_OUT:    w.fin = 1'b1;
      default:     w.fin = 1'b1;
    endcase
    return w;
  endfunction

  logic [sbeq_pkg::STEP_W-1:0] pc_q, pc_d;
  logic [sbeq_pkg::BAND_W-1:0] band_q, band_d;
  logic                        busy_q, busy_d;
  sbeq_pkg::ctrl_t             word;

  assign word   = rom(pc_q);
  assign busy_o = busy_q;
  assign band_o = band_q;

  always_comb begin
    ctrl_o = word;
    if (!busy_q) begin
      ctrl_o = '{mul_sel: sbeq_pkg::MUL_NONE, upd_sel: sbeq_pkg::UPD_NONE,
                 acc_add: 1'b0, band_inc: 1'b0, jmp: 1'b0, target: STEP_HP_MUL,
                 fin: 1'b0};
    end
  end

  always_comb begin
    pc_d   = pc_q;
    band_d = band_q;
    busy_d = busy_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        band_d = '0;
        pc_d   = clear_i ? STEP_OUT : STEP_HP_MUL;
      end
    end else if (word.fin) begin
      if (!stall_i) begin
        busy_d = 1'b0;
      end
    end else begin
      pc_d = pc_q + 1'b1;
      if (word.jmp && band_q != LAST_BAND) begin
        pc_d = word.target;
      end
      if (word.band_inc) begin
        band_d = (band_q == LAST_BAND) ? '0 : band_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= STEP_HP_MUL;
      band_q <= '0;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      band_q <= band_d;
      busy_q <= busy_d;
    end
  end

endmodule

FILE: rtl/core/six_band_tone_stack_eq_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// six_band_tone_stack_eq_unit: six-band graphic equaliser
// Halved sample through six parallel one-pole band-pass filters, weighted by
// level registers and mixed back with the dry path, rounded and saturated.
// ----------------------------------------------------------------------------
// A sample request runs five sequencer steps per band for six bands on one
// shared 35x25 multiplier, then one accumulate and one output step; a clear
// request takes one step. A new request is taken whenever the
// sequencer is idle, even while the previous result waits in the output
// register. Level registers are written through the cfg port (index 0..5,
// other indexes dropped) and should be written only while the block is idle.
module six_band_tone_stack_eq_unit #(
  parameter int unsigned SAMPLE_RATE  = sbeq_pkg::DEF_SAMPLE_RATE,
  parameter int unsigned SAMPLE_WIDTH = sbeq_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,  // sample_in
  input  logic                                   s_axis_tuser,  // op
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      m_axis_tdata,  // sample_out
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [sbeq_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [sbeq_pkg::LEVEL_W-1:0]           cfg_data_i
);

  localparam int unsigned W      = SAMPLE_WIDTH;
  localparam int unsigned DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int unsigned RATE   = (SAMPLE_RATE < sbeq_pkg::MIN_RATE) ?
                                   sbeq_pkg::MIN_RATE : SAMPLE_RATE;
  localparam int unsigned OUT_SH = 47 - SAMPLE_WIDTH;
  localparam int unsigned SHW    = sbeq_pkg::ACC_W - OUT_SH;
  localparam int unsigned NB     = sbeq_pkg::NUM_BANDS;
  localparam int unsigned SW     = sbeq_pkg::STATE_W;

  // ---------------------------------------------------------------- tables
  logic [sbeq_pkg::COEF_W-1:0] coef_hp_tab [NB];
  logic [sbeq_pkg::COEF_W-1:0] coef_lp_tab [NB];

  for (genvar g = 0; g < NB; g++) begin : g_coef
    localparam logic [sbeq_pkg::COEF_W-1:0] CHP =
      sbeq_pkg::make_coef(sbeq_pkg::HP_FREQ[g], RATE);
    localparam logic [sbeq_pkg::COEF_W-1:0] CLP =
      sbeq_pkg::make_coef(sbeq_pkg::LP_FREQ[g], RATE);
    assign coef_hp_tab[g] = CHP;
    assign coef_lp_tab[g] = CLP;
  end

  // ------------------------------------------------------------- handshake
  logic                          busy, in_acc, stall, op_clear;
  logic [sbeq_pkg::BAND_W-1:0]   band;
  sbeq_pkg::ctrl_t               ctrl;

  assign s_axis_tready = !busy;
  assign in_acc        = s_axis_tvalid && !busy;
  assign op_clear      = s_axis_tuser;
  assign cfg_ready_o   = 1'b1;

  logic m_valid_q;
  logic [W-1:0] m_data_q;
  assign stall         = m_valid_q && !m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = DATA_W'(m_data_q);

  sbeq_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .clear_i (op_clear),
    .stall_i (stall),
    .busy_o  (busy),
    .band_o  (band),
    .ctrl_o  (ctrl)
  );

  // ---------------------------------------------------------- input scaling
  logic signed [W-1:0]                 sx;
  logic signed [sbeq_pkg::HALF_W-1:0]  half_calc;

  assign sx = $signed(s_axis_tdata[W-1:0]);

  if (SAMPLE_WIDTH <= 29) begin : g_half_shl
    assign half_calc = sbeq_pkg::HALF_W'(sx) <<< (29 - SAMPLE_WIDTH);
  end else begin : g_half_rnd
    localparam int unsigned RSH = SAMPLE_WIDTH - 29;
    logic signed [W:0] sx_rnd;
    assign sx_rnd    = (W+1)'(sx) + (W+1)'(1 << (RSH - 1));
    assign half_calc = sbeq_pkg::HALF_W'(sx_rnd >>> RSH);
  end

  // --------------------------------------------------------------- datapath
  logic        [sbeq_pkg::LEVEL_W-1:0] level_q [NB];
  logic signed [SW-1:0]                st_q    [2*NB];
  logic signed [sbeq_pkg::HALF_W-1:0]  half_q;
  logic signed [sbeq_pkg::HP_W-1:0]    hp_q;
  logic signed [sbeq_pkg::PROD_W-1:0]  prod_q, prod_d;
  logic signed [sbeq_pkg::ACC_W-1:0]   acc_q;
  logic signed [sbeq_pkg::GAIN_W-1:0]  gain_q, gain_d;

  logic signed [sbeq_pkg::DIFF_W-1:0]  mul_a;
  logic signed [sbeq_pkg::MUL_B_W-1:0] mul_b;
  logic        [21:0]                  gain_raw;
  logic        [sbeq_pkg::LEVEL_W-1:0] level_sel;

  always_comb begin
    level_sel = level_q[sbeq_pkg::LEVEL_MAP[band]];
    gain_raw  = 22'(level_sel) * 22'(sbeq_pkg::GAIN_MUL[band]);
    gain_d    = $signed(sbeq_pkg::GAIN_W'(gain_raw)
                - (sbeq_pkg::GAIN_W'(sbeq_pkg::GAIN_OFF[band]) << 16));
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.mul_sel)
      sbeq_pkg::MUL_HP: begin
        mul_a = sbeq_pkg::DIFF_W'(half_q) - sbeq_pkg::DIFF_W'(st_q[0]);
        mul_b = $signed({1'b0, coef_hp_tab[band]});
      end
      sbeq_pkg::MUL_LP: begin
        mul_a = sbeq_pkg::DIFF_W'(hp_q) - sbeq_pkg::DIFF_W'(st_q[1]);
        mul_b = $signed({1'b0, coef_lp_tab[band]});
      end
      sbeq_pkg::MUL_GAIN: begin
        mul_a = sbeq_pkg::DIFF_W'(st_q[1]);
        mul_b = sbeq_pkg::MUL_B_W'(gain_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = (ctrl.mul_sel == sbeq_pkg::MUL_NONE) ? prod_q : mul_a * mul_b;
  end

  // pole update: p + round(prod / 2^24), saturated to the state width
  localparam int unsigned DW = sbeq_pkg::PROD_W - sbeq_pkg::FRAC_SH;
  logic signed [sbeq_pkg::PROD_W-1:0] prod_rnd;
  logic signed [DW-1:0]               delta;
  logic signed [DW:0]                 p_sum;
  logic signed [SW-1:0]               p_cur, p_new;
  logic signed [sbeq_pkg::HP_W-1:0]   hp_new;

  always_comb begin
    prod_rnd = prod_q + (sbeq_pkg::PROD_W'(1) <<< (sbeq_pkg::FRAC_SH - 1));
    delta    = prod_rnd[sbeq_pkg::PROD_W-1:sbeq_pkg::FRAC_SH];
    p_cur    = (ctrl.upd_sel == sbeq_pkg::UPD_HP) ? st_q[0] : st_q[1];
    p_sum    = (DW+1)'(p_cur) + (DW+1)'(delta);
    if ((&p_sum[DW:SW-1]) || !(|p_sum[DW:SW-1])) begin
      p_new = p_sum[SW-1:0];
    end else if (p_sum[DW]) begin
      p_new = {1'b1, {(SW-1){1'b0}}};
    end else begin
      p_new = {1'b0, {(SW-1){1'b1}}};
    end
    hp_new = sbeq_pkg::HP_W'(half_q) - sbeq_pkg::HP_W'(p_new);
  end

  // output rounding and saturation
  logic signed [sbeq_pkg::ACC_W-1:0] acc_rnd;
  logic signed [SHW-1:0]             y_wide;
  logic        [W-1:0]               y;

  always_comb begin
    acc_rnd = acc_q + (sbeq_pkg::ACC_W'(1) <<< (OUT_SH - 1));
    y_wide  = acc_rnd[sbeq_pkg::ACC_W-1:OUT_SH];
    if ((&y_wide[SHW-1:W-1]) || !(|y_wide[SHW-1:W-1])) begin
      y = y_wide[W-1:0];
    end else if (y_wide[SHW-1]) begin
      y = {1'b1, {(W-1){1'b0}}};
    end else begin
      y = {1'b0, {(W-1){1'b1}}};
    end
  end

  // -------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NB; i++) begin
        level_q[i] <= sbeq_pkg::LEVEL_RESET[i];
      end
    end else if (cfg_valid_i && cfg_index_i < sbeq_pkg::CFG_IDX_W'(NB)) begin
      level_q[cfg_index_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2*NB; i++) begin
        st_q[i] <= '0;
      end
    end else if (in_acc && op_clear) begin
      for (int i = 0; i < 2*NB; i++) begin
        st_q[i] <= '0;
      end
    end else if (ctrl.upd_sel == sbeq_pkg::UPD_HP) begin
      st_q[0] <= p_new;
    end else if (ctrl.upd_sel == sbeq_pkg::UPD_LP) begin
      st_q[1] <= p_new;
    end else if (ctrl.band_inc) begin
      // rotate so the next band's pair sits at the front
      for (int i = 0; i < 2*NB - 2; i++) begin
        st_q[i] <= st_q[i+2];
      end
      st_q[2*NB-2] <= st_q[0];
      st_q[2*NB-1] <= st_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    gain_q <= gain_d;
    if (in_acc) begin
      half_q <= half_calc;
      prod_q <= '0;
      acc_q  <= op_clear ? '0 : sbeq_pkg::ACC_W'(half_calc) <<< 16;
    end else begin
      prod_q <= prod_d;
      if (ctrl.acc_add) begin
        acc_q <= acc_q + sbeq_pkg::ACC_W'(prod_q);
      end
    end
    if (ctrl.upd_sel == sbeq_pkg::UPD_HP) begin
      hp_q <= hp_new;
    end
    if (ctrl.fin && !stall) begin
      m_data_q <= y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctrl.fin && !stall) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

endmodule

FILE: tb/sv/tb_six_band_tone_stack_eq_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_six_band_tone_stack_eq_unit: self-checking bench for the six-band equaliser
// Streams sample and clear requests through the block under several level
// settings and compares each output sample against a bit-exact fixed-point
// model of the six band-pass filters, with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_six_band_tone_stack_eq_unit;

  localparam int unsigned SAMPLE_RATE = 48000;
  localparam int unsigned SW          = 24;
  localparam int unsigned DATA_W      = ((SW + 7) / 8) * 8;
  localparam int unsigned RATE_EFF    = (SAMPLE_RATE < 44100) ? 44100 : SAMPLE_RATE;
  localparam int unsigned NBANDS      = sbeq_pkg::NUM_BANDS;
  localparam int unsigned LVL_W       = sbeq_pkg::LEVEL_W;
  localparam longint unsigned CYCLE_LIMIT = 1000000;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [SW-1:0] S_MAX = {1'b0, {(SW - 1){1'b1}}};
  localparam logic [SW-1:0] S_MIN = {1'b1, {(SW - 1){1'b0}}};
  localparam logic [LVL_W-1:0] L_TOP = {LVL_W{1'b1}};

  localparam longint unsigned Q56_UNIT = 64'h0100_0000_0000_0000;
  localparam longint unsigned PI_Q56   = 64'h0324_3F6A_8885_A309;

  localparam int BAND_HP_HZ [6] = '{30, 300, 120, 1000, 900, 3000};
  localparam int BAND_LP_HZ [6] = '{120, 500, 900, 2000, 20000, 20000};
  localparam int BAND_LEVEL [6] = '{0, 3, 1, 4, 2, 5};
  localparam int BAND_MUL   [6] = '{8, 4, 4, 4, 8, 24};
  localparam int BAND_OFF   [6] = '{0, 0, 2, 0, 2, 12};

  typedef enum logic [sbeq_pkg::CFG_IDX_W-1:0] {
    LVL_BAND0  = 3'd0,
    LVL_BAND1  = 3'd1,
    LVL_BAND2  = 3'd2,
    LVL_BAND3  = 3'd3,
    LVL_BAND4  = 3'd4,
    LVL_BAND5  = 3'd5,
    LVL_SPARE6 = 3'd6,
    LVL_SPARE7 = 3'd7
  } level_reg_e;

  typedef logic [LVL_W-1:0] level_set_t [NBANDS];

  class tone_stack_model;
    logic [LVL_W-1:0]   levels [NBANDS];
    logic signed [31:0] poles [2*NBANDS];
    logic [23:0]        hp_coef [NBANDS];
    logic [23:0]        lp_coef [NBANDS];
    logic [SW-1:0]      expected_samples [$];
    int unsigned        mismatches;

    function new();
      for (int k = 0; k < NBANDS; k++) begin
        hp_coef[k] = pole_coef(BAND_HP_HZ[k], RATE_EFF);
        lp_coef[k] = pole_coef(BAND_LP_HZ[k], RATE_EFF);
        poles[2*k]   = '0;
        poles[2*k+1] = '0;
      end
      levels = '{17'd32768, 17'd32768, 17'd32768, 17'd0, 17'd0, 17'd0};
      mismatches = 0;
    endfunction

    static function longint unsigned q56_mul(longint unsigned a, longint unsigned b);
      longint unsigned ah, al, bh, bl, mid;
      ah  = a >> 28;
      al  = a & 64'h0FFF_FFFF;
      bh  = b >> 28;
      bl  = b & 64'h0FFF_FFFF;
      mid = ah * bl + al * bh + ((al * bl) >> 28);
      return ah * bh + (mid >> 28);
    endfunction

    // 1 - exp(-2*pi*f/rate) as a Q0.24 value, via the exp series in Q56
    static function logic [23:0] pole_coef(int hz, int unsigned rate);
      longint unsigned tp, x, term, r64, f64;
      longint sum, c;
      tp   = 2 * PI_Q56;
      r64  = 64'(rate);
      f64  = 64'(hz);
      x    = (tp / r64) * f64 + ((tp % r64) * f64) / r64;
      term = Q56_UNIT;
      sum  = longint'(Q56_UNIT);
      for (int n = 1; n <= 64; n++) begin
        term = q56_mul(term, x) / 64'(n);
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      c = longint'(Q56_UNIT) - sum;
      if (c < 0) begin
        c = 0;
      end
      c = (c + (64'sd1 <<< 31)) >>> 32;
      return c[23:0];
    endfunction

    static function longint round_shr(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    static function longint clamp(longint v, int w);
      longint hi, lo;
      hi = (64'sd1 <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    static function logic signed [31:0] pole_step(logic signed [31:0] p, longint x,
                                                  logic [23:0] c);
      longint d, sum;
      d   = round_shr((x - longint'(p)) * longint'({40'd0, c}), 24);
      sum = clamp(longint'(p) + d, 32);
      return sum[31:0];
    endfunction

    function void set_level(level_reg_e idx, logic [LVL_W-1:0] value);
      if (int'(idx) < NBANDS) begin
        levels[idx] = value;
      end
    endfunction

    function int unsigned pending();
      return expected_samples.size();
    endfunction

    function void note_request(logic op, logic [SW-1:0] smp);
      longint half, acc, hp, gain, y;
      logic signed [31:0] p0, p1;
      if (op == OP_CLEAR) begin
        for (int k = 0; k < 2 * NBANDS; k++) begin
          poles[k] = '0;
        end
        expected_samples.push_back('0);
        return;
      end
      half = longint'($signed(smp)) * (64'sd1 <<< (29 - SW));
      acc  = half * 65536;
      for (int k = 0; k < NBANDS; k++) begin
        p0   = pole_step(poles[2*k], half, hp_coef[k]);
        hp   = half - longint'(p0);
        p1   = pole_step(poles[2*k+1], hp, lp_coef[k]);
        gain = longint'({47'd0, levels[BAND_LEVEL[k]]}) * BAND_MUL[k]
               - longint'(BAND_OFF[k]) * 65536;
        poles[2*k]   = p0;
        poles[2*k+1] = p1;
        acc = acc + longint'(p1) * gain;
      end
      y = clamp(round_shr(acc, 47 - SW), SW);
      expected_samples.push_back(y[SW-1:0]);
    endfunction

    function void check_sample(logic [SW-1:0] actual);
      logic [SW-1:0] want;
      if (expected_samples.size() == 0) begin
        $error("sample_out: expected none, actual %0d", $signed(actual));
        mismatches++;
        return;
      end
      want = expected_samples.pop_front();
      if (actual !== want) begin
        $error("sample_out: expected %0d, actual %0d", $signed(want), $signed(actual));
        mismatches++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               s_tvalid;
  logic               s_tready;
  logic [DATA_W-1:0]  s_tdata;
  logic               s_tuser;
  logic               m_tvalid;
  logic               m_tready;
  logic [DATA_W-1:0]  m_tdata;
  logic               cfg_valid;
  logic               cfg_ready;
  level_reg_e         cfg_index;
  logic [LVL_W-1:0]   cfg_data;

  tone_stack_model    eq_model;
  longint unsigned    cycle_count = 0;
  int unsigned        results_seen = 0;
  int unsigned        hold_left = 0;
  int unsigned        rx_tick = 0;
  int unsigned        rx_mode = 0;

  six_band_tone_stack_eq_unit #(
    .SAMPLE_RATE (SAMPLE_RATE),
    .SAMPLE_WIDTH(SW)
  ) u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // sink: check results, stall on a changing pattern, hold off twice
  always @(posedge clk) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        eq_model.check_sample(m_tdata[SW-1:0]);
        results_seen++;
        if (results_seen == 150 || results_seen == 650) begin
          hold_left = 400;
        end
      end
      rx_tick++;
      if (rx_tick % 97 == 0) begin
        rx_mode = $urandom_range(0, 3);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= (rx_tick % 4 == 0);
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic offer_request(input logic op, input logic [SW-1:0] smp);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= DATA_W'(smp);
    do @(posedge clk); while (!s_tready);
    eq_model.note_request(op, smp);
  endtask

  task automatic sender_pause(input int unsigned cycles);
    s_tvalid <= 1'b0;
    s_tdata  <= DATA_W'($urandom);
    s_tuser  <= 1'($urandom_range(0, 1));
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (eq_model.pending() > 0) @(posedge clk);
  endtask

  task automatic program_levels(input level_set_t lv, input bit touch_spare);
    logic [LVL_W-1:0] junk;
    for (int i = 0; i < NBANDS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= level_reg_e'(i);
      cfg_data  <= lv[i];
      do @(posedge clk); while (!cfg_ready);
      eq_model.set_level(level_reg_e'(i), lv[i]);
    end
    if (touch_spare) begin
      for (int i = LVL_SPARE6; i <= LVL_SPARE7; i++) begin
        junk = LVL_W'($urandom);
        cfg_index <= level_reg_e'(i);
        cfg_data  <= junk;
        do @(posedge clk); while (!cfg_ready);
        eq_model.set_level(level_reg_e'(i), junk);
      end
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [LVL_W-1:0] pick_level();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 17'd65536;
      2: return L_TOP;
      3: return 17'd32768;
      default: return LVL_W'($urandom_range(0, 131071));
    endcase
  endfunction

  function automatic logic [SW-1:0] pick_sample(input logic [SW-1:0] prev);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return SW'($urandom);
    if (roll < 60) return SW'(int'($urandom_range(0, 8191)) - 4096);
    if (roll < 75) return $urandom_range(0, 1) ? S_MAX : S_MIN;
    return prev;
  endfunction

  task automatic random_phase(input int unsigned items);
    logic [SW-1:0] smp;
    logic          op;
    int unsigned   burst_left;
    smp = '0;
    burst_left = $urandom_range(1, 30);
    for (int n = 0; n < items; n++) begin
      op  = ($urandom_range(0, 99) < 3) ? OP_CLEAR : OP_SAMPLE;
      smp = pick_sample(smp);
      offer_request(op, smp);
      burst_left = burst_left - 1;
      if (burst_left == 0) begin
        sender_pause($urandom_range(1, 45));
        burst_left = $urandom_range(1, 30);
      end
    end
    drain_results();
  endtask

  initial begin
    level_set_t lv;
    eq_model  = new();
    rst_n     <= 1'b0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= OP_SAMPLE;
    cfg_valid <= 1'b0;
    cfg_index <= LVL_BAND0;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset levels: extremes, small values, clear
    offer_request(OP_SAMPLE, '0);
    repeat (3) offer_request(OP_SAMPLE, S_MAX);
    repeat (3) offer_request(OP_SAMPLE, S_MIN);
    offer_request(OP_SAMPLE, SW'(1));
    offer_request(OP_SAMPLE, '1);
    offer_request(OP_CLEAR, SW'($urandom));
    offer_request(OP_SAMPLE, 24'h5A5A5A);
    offer_request(OP_SAMPLE, 24'hA5A5A5);
    drain_results();

    // top levels: drive the output into saturation both ways
    lv = '{L_TOP, L_TOP, L_TOP, L_TOP, L_TOP, L_TOP};
    program_levels(lv, 1'b1);
    for (int i = 0; i < 4; i++) begin
      offer_request(OP_SAMPLE, S_MAX);
      offer_request(OP_SAMPLE, S_MIN);
    end
    offer_request(OP_CLEAR, S_MAX);
    offer_request(OP_SAMPLE, S_MAX);
    drain_results();

    lv = '{17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0};
    program_levels(lv, 1'b0);
    random_phase(215);

    lv = '{17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536};
    program_levels(lv, 1'b1);
    random_phase(215);

    for (int p = 0; p < 2; p++) begin
      for (int i = 0; i < NBANDS; i++) begin
        lv[i] = pick_level();
      end
      program_levels(lv, 1'b1);
      random_phase(215);
    end

    lv = '{17'd32768, 17'd32768, 17'd32768, 17'd0, 17'd0, 17'd0};
    program_levels(lv, 1'b0);
    random_phase(215);

    repeat (64) @(posedge clk);
    if (eq_model.mismatches == 0 && eq_model.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
